@@ rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle check: whenever ante holds, cons must hold too.
`define KST_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle check: whenever ante holds, cons must hold in the cycle after.
`define KST_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/kst_pkg.sv @@
package kst_pkg;

  localparam int KEY_LO_W  = 64;
  localparam int KEY_HI_W  = 56;
  localparam int KEY_W     = KEY_LO_W + KEY_HI_W;
  localparam int KEY_MAX_B = KEY_W / 8;
  localparam int SCORE_W   = 16;

  typedef logic signed [SCORE_W-1:0] score_t;
  typedef logic [KEY_W-1:0]          key_t;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_UPDATE = 2'd1,
    OP_REMOVE = 2'd2,
    OP_LOOKUP = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_MISSING = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef struct packed {
    op_t                  operation;
    logic [KEY_LO_W-1:0]  key_low;
    logic [KEY_HI_W-1:0]  key_high;
    score_t               score;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [3:0]  found_index;
    score_t      stored_score;
    logic [4:0]  entry_count;
  } out_item_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic cmp_en;
    logic act;
    op_t  op;
    logic full;
  } kst_ctl_t;

  // Passed from cell to cell: has an earlier cell matched, and its score.
  typedef struct packed {
    logic   hit;
    score_t score;
  } kst_chain_t;

endpackage

@@ rtl/kst_norm.sv @@
module kst_norm #(
  parameter int KEY_BYTES = 15
) (
  input  logic [kst_pkg::KEY_LO_W-1:0] key_low,
  input  logic [kst_pkg::KEY_HI_W-1:0] key_high,
  output kst_pkg::key_t                key_out
);
  import kst_pkg::*;

  key_t                 raw;
  logic [KEY_MAX_B-1:0] nz;
  logic [KEY_MAX_B-1:0] keep;

  assign raw = {key_high, key_low};

  // A byte survives only if it and every byte below it are non-zero and it
  // lies inside the key length. The first zero byte thus clears every byte above it.
  always_comb begin
    logic [KEY_MAX_B-1:0] below;
    for (int b = 0; b < KEY_MAX_B; b++) begin
      nz[b] = |raw[8*b +: 8];
    end
    for (int b = 0; b < KEY_MAX_B; b++) begin
      below = '0;
      for (int j = 0; j < KEY_MAX_B; j++) begin
        below[j] = (j <= b);
      end
      keep[b] = (b < KEY_BYTES) && (&(nz | ~below));
    end
    for (int b = 0; b < KEY_MAX_B; b++) begin
      key_out[8*b +: 8] = keep[b] ? raw[8*b +: 8] : 8'h00;
    end
  end

endmodule

@@ rtl/kst_cell.sv @@
module kst_cell #(
  parameter int IDX = 0,
  parameter int CW  = 5,
  parameter int IW  = 4
) (
  input  logic                clk,
  input  kst_pkg::kst_ctl_t   ctl,
  input  logic [CW-1:0]       count,
  input  kst_pkg::key_t       cmp_key,
  input  kst_pkg::key_t       ld_key,
  input  kst_pkg::score_t     ld_score,
  input  kst_pkg::key_t       nb_key,
  input  kst_pkg::score_t     nb_score,
  output kst_pkg::key_t       key,
  output kst_pkg::score_t     score,
  input  kst_pkg::kst_chain_t chain_in,
  input  logic [IW-1:0]       idx_in,
  output kst_pkg::kst_chain_t chain_out,
  output logic [IW-1:0]       idx_out
);
  import kst_pkg::*;

  key_t   key_r;
  score_t score_r;
  logic   match_r;
  logic   first;

  assign key   = key_r;
  assign score = score_r;

  // This cell holds the lowest matching entry when it matches and no
  // cell to its left has.
  assign first           = match_r & ~chain_in.hit;
  assign chain_out.hit   = chain_in.hit | match_r;
  assign chain_out.score = chain_in.score | (first ? score_r : '0);
  assign idx_out         = idx_in | (first ? IW'(IDX) : '0);

  always_ff @(posedge clk) begin
    if (ctl.cmp_en) begin
      match_r <= (cmp_key == key_r) && (CW'(IDX) < count);
    end
    if (ctl.act) begin
      case (ctl.op)
        OP_ADD: begin
          if (!ctl.full && (count == CW'(IDX))) begin
            key_r   <= ld_key;
            score_r <= ld_score;
          end
        end
        OP_UPDATE: begin
          if (first) begin
            score_r <= ld_score;
          end
        end
        OP_REMOVE: begin
          // Every cell at or after the removed one takes its right neighbour.
          if (chain_out.hit) begin
            key_r   <= nb_key;
            score_r <= nb_score;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/keyed_score_table_top.sv @@
// Keyed score table: up to ENTRIES entries of a zero-padded key and a signed
// score, kept packed from index 0 in a row of cells. Each word in gives one
// word out. In the accepting cycle of an operation the normalised key is
// compared against every cell at once, and in S_ACT, once the output
// register is free, the hit chain running through the cells picks the
// lowest match and the add, score update or shift-down remove is applied
// while the result is registered. in_ready is high whenever no operation
// is in flight, so a new word is taken only after the last one is applied;
// a result left untaken holds back the S_ACT step of the following
// operation. There is no clearing pass after reset.
`include "assert_macros.svh"

module keyed_score_table_top #(
  parameter int ENTRIES   = 16,
  parameter int KEY_BYTES = 15
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  kst_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output kst_pkg::out_item_t out_data
);
  import kst_pkg::*;

  localparam int IW  = (ENTRIES > 2) ? $clog2(ENTRIES) : 1;
  localparam int CW  = $clog2(ENTRIES + 1);
  localparam int IXW = (IW > 4) ? IW : 4;
  localparam int CXW = (CW > 5) ? CW : 5;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_ACT  = 2'b10
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  op_t           op_r;
  key_t          key_r;
  score_t        score_r;
  out_item_t     out_r, out_nxt;
  logic          out_valid_r, out_valid_nxt;

  key_t          norm_key;
  logic          accept;
  logic          act;
  logic          full;
  kst_ctl_t      ctl;

  key_t          cell_key   [ENTRIES];
  score_t        cell_score [ENTRIES];
  kst_chain_t    chain      [ENTRIES+1];
  logic [IW-1:0] idx_chain  [ENTRIES+1];

  logic [IXW-1:0] idx_x;
  logic [CXW-1:0] cnt_x;
  logic [IW-1:0]  res_idx;

  kst_norm #(
    .KEY_BYTES (KEY_BYTES)
  ) u_norm (
    .key_low  (in_data.key_low),
    .key_high (in_data.key_high),
    .key_out  (norm_key)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign act       = (state_r == S_ACT) && (!out_valid_r || out_ready);
  assign full      = (count_r == CW'(ENTRIES));
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign ctl.cmp_en = accept;
  assign ctl.act    = act;
  assign ctl.op     = op_r;
  assign ctl.full   = full;

  assign chain[0]     = '0;
  assign idx_chain[0] = '0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    key_t   nb_key;
    score_t nb_score;
    if (i == ENTRIES - 1) begin : g_last
      assign nb_key   = cell_key[i];
      assign nb_score = cell_score[i];
    end else begin : g_mid
      assign nb_key   = cell_key[i+1];
      assign nb_score = cell_score[i+1];
    end
    kst_cell #(
      .IDX (i),
      .CW  (CW),
      .IW  (IW)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .count     (count_r),
      .cmp_key   (norm_key),
      .ld_key    (key_r),
      .ld_score  (score_r),
      .nb_key    (nb_key),
      .nb_score  (nb_score),
      .key       (cell_key[i]),
      .score     (cell_score[i]),
      .chain_in  (chain[i]),
      .idx_in    (idx_chain[i]),
      .chain_out (chain[i+1]),
      .idx_out   (idx_chain[i+1])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    res_idx       = '0;
    idx_x         = '0;
    cnt_x         = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (accept) begin
      state_nxt = S_ACT;
    end

    if (act) begin
      out_nxt.status       = ST_OK;
      out_nxt.stored_score = '0;
      if (op_r == OP_ADD) begin
        if (full) begin
          out_nxt.status = ST_FULL;
        end else begin
          res_idx   = count_r[IW-1:0];
          count_nxt = count_r + CW'(1);
        end
      end else if (!chain[ENTRIES].hit) begin
        out_nxt.status = ST_MISSING;
      end else begin
        res_idx = idx_chain[ENTRIES];
        if (op_r == OP_REMOVE) begin
          count_nxt = count_r - CW'(1);
        end
        if (op_r == OP_LOOKUP) begin
          out_nxt.stored_score = chain[ENTRIES].score;
        end
      end
      idx_x               = IXW'(res_idx);
      cnt_x               = CXW'(count_nxt);
      out_nxt.found_index = idx_x[3:0];
      out_nxt.entry_count = cnt_x[4:0];
      out_valid_nxt       = 1'b1;
      state_nxt           = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (accept) begin
      op_r    <= in_data.operation;
      key_r   <= norm_key;
      score_r <= in_data.score;
    end
  end

  `KST_ASSERT_IMP(a_count_range, clk, rst_n, 1'b1, count_r <= CW'(ENTRIES),
    "entry count exceeds table size")
  `KST_ASSERT_NXT(a_accept_blocks, clk, rst_n, accept, !in_ready,
    "a second word was accepted before the first finished")
  `KST_ASSERT_NXT(a_act_result, clk, rst_n, act, out_valid_r,
    "operation completed without a result")
  `KST_ASSERT_NXT(a_add_grows, clk, rst_n, act && (op_r == OP_ADD) && !full,
    count_r == $past(count_r) + CW'(1), "add into free slot did not grow the table")
  `KST_ASSERT_NXT(a_count_still, clk, rst_n, !act, $stable(count_r),
    "entry count changed with no operation")

endmodule
